// ===== hdl/crc6w_pkg.sv =====
// package: widths, byte table and shared types of the 6-bit word check
`timescale 1ns / 1ps

package crc6w_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CHECK_W   = 6;
  localparam int unsigned NUM_BYTES = WORD_W / BYTE_W;

  // table rows for the single-bit indices, lsb first; the table is linear
  localparam logic [BYTE_W-1:0] BIT_COLUMN [BYTE_W] = '{
    8'h6c, 8'hd8, 8'hdc, 8'hd4, 8'hc4, 8'he4, 8'ha4, 8'h24
  };

  // item as it travels down the lookup stages
  typedef struct packed {
    logic [WORD_W-1:0]  data_word;
    logic [CHECK_W-1:0] received_check;
    logic [BYTE_W-1:0]  crc;
  } stage_data_t;

  // byte table lookup as an xor network
  function automatic logic [BYTE_W-1:0] byte_map(input logic [BYTE_W-1:0] idx);
    logic [BYTE_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (idx[k]) begin
        acc = acc ^ BIT_COLUMN[k];
      end
    end
    return acc;
  endfunction

endpackage

// ===== hdl/crc6w_if.sv =====
// interfaces: input item channel and result item channel
`timescale 1ns / 1ps

interface crc6w_in_if
  import crc6w_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  data_word;
  logic [CHECK_W-1:0] received_check;

  modport source (output valid, output data_word, output received_check, input ready);
  modport sink   (input valid, input data_word, input received_check, output ready);
endinterface

interface crc6w_out_if
  import crc6w_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CHECK_W-1:0] check_value;
  logic               check_match;

  modport source (output valid, output check_value, output check_match, input ready);
  modport sink   (input valid, input check_value, input check_match, output ready);
endinterface

// ===== hdl/crc6w_stage.sv =====
// one byte lookup stage of the check pipeline
`timescale 1ns / 1ps

module crc6w_stage
  import crc6w_pkg::*;
#(
  parameter int unsigned BYTE_SEL = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  stage_data_t up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output stage_data_t dn_data
);

  localparam int unsigned HI_BIT = WORD_W - 1 - BYTE_SEL * BYTE_W;

  logic        valid_r;
  stage_data_t data_r;
  stage_data_t data_nxt;

  // stage takes an item when empty or when its item moves on
  assign up_ready = !valid_r || dn_ready;

  // next byte folded into the running remainder
  always_comb begin
    data_nxt     = up_data;
    data_nxt.crc = byte_map(up_data.data_word[HI_BIT -: BYTE_W] ^ up_data.crc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== hdl/crc6w_out_stage.sv =====
// output register: final inversion and compare with the received check
`timescale 1ns / 1ps

module crc6w_out_stage
  import crc6w_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  stage_data_t up_data,
  crc6w_out_if.source out_ch
);

  logic               valid_r;
  logic [CHECK_W-1:0] check_r;
  logic               match_r;
  logic [CHECK_W-1:0] check_nxt;
  logic               match_nxt;

  assign up_ready = !valid_r || out_ch.ready;

  // drop the two low remainder bits and invert
  assign check_nxt = ~up_data.crc[BYTE_W-1 -: CHECK_W];
  assign match_nxt = (check_nxt == up_data.received_check);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      check_r <= check_nxt;
      match_r <= match_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.check_value = check_r;
  assign out_ch.check_match = match_r;

endmodule

// ===== hdl/crc6_over_word.sv =====
// crc6_over_word: 6-bit inverted check over a 32-bit word, pipelined
//
// in_ch carries a 32-bit data word and a 6-bit received check; an item is
// taken at a clock edge where valid and ready are both high. out_ch returns
// one result item per input item, in order: the computed 6-bit check and a
// flag that is high when it equals the received check.
// The word goes through four byte lookup stages, most significant byte
// first, then an output register that inverts and compares. Throughput is
// one item per cycle while out_ch.ready stays high, set by one table lookup
// per register stage.
// Each stage holds its own item with a valid bit; when the receiver drops
// out_ch.ready the stages fill up and in_ch.ready falls once all five are
// full, so nothing is lost or repeated. ready travels back combinationally.
// A synchronous reset (rst_n low) empties the pipeline; no item in flight
// is delivered afterwards. There is no configuration and no kept state.
`timescale 1ns / 1ps

module crc6_over_word
  import crc6w_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  crc6w_in_if.sink    in_ch,
  crc6w_out_if.source out_ch
);

  logic        stg_valid [NUM_BYTES+1];
  logic        stg_ready [NUM_BYTES+1];
  stage_data_t stg_data  [NUM_BYTES+1];

  // input item enters with an empty remainder
  assign stg_valid[0]               = in_ch.valid;
  assign in_ch.ready                = stg_ready[0];
  assign stg_data[0].data_word      = in_ch.data_word;
  assign stg_data[0].received_check = in_ch.received_check;
  assign stg_data[0].crc            = '0;

  // one lookup stage per byte
  for (genvar g = 0; g < NUM_BYTES; g++) begin : g_byte
    crc6w_stage #(
      .BYTE_SEL (g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_data  (stg_data[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_data  (stg_data[g+1])
    );
  end

  // result register
  crc6w_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stg_valid[NUM_BYTES]),
    .up_ready (stg_ready[NUM_BYTES]),
    .up_data  (stg_data[NUM_BYTES]),
    .out_ch   (out_ch)
  );

endmodule

// ===== hdl/crc6w_checker.sv =====
// checker on the top level ports, bound to crc6_over_word
`timescale 1ns / 1ps

module crc6w_checker
  import crc6w_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CHECK_W-1:0] out_check_value,
  input logic               out_check_match
);

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn while stalled");

  // a stalled result item keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_check_value) && $stable(out_check_match))
    else $error("result item changed while stalled");

  // a free receiver lets the whole pipeline move, so input is never blocked
  a_no_block: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("input blocked while receiver ready");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result item shown right after reset");

  // with the receiver free, an accepted item is offered once it has passed the lookup stages and the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready [*4] |=> out_valid)
    else $error("result item missing after pipeline latency");

endmodule

bind crc6_over_word crc6w_checker u_crc6w_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_check_value (out_ch.check_value),
  .out_check_match (out_ch.check_match)
);
